// File: hw/rtl/sgm_pkg.sv
package sgm_pkg;

  localparam int MAX_WIDTH_DEF = 512;
  localparam int QUEUE_DEPTH   = 4;

  localparam int LW_W   = 10;
  localparam int FH_W   = 12;
  localparam int CFG_W  = 12;
  localparam int PIX_W  = 8;
  localparam int MAG_W  = 11;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 9;
  localparam int SUM_W  = 11;
  localparam int SQ_W   = 21;

  localparam logic [0:0] CFG_LINE_WIDTH   = 1'd0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 10'd512;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd512;
  localparam logic [FH_W-1:0] MIN_DIM          = 12'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_frame;
  } out_t;

  typedef struct packed {
    logic [LW_W-1:0] line_width;
    logic [FH_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    last_of_frame;
  } work_t;

endpackage

// File: hw/rtl/sgm_front.sv
module sgm_front #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sgm_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  sgm_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output sgm_pkg::work_t push_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = sgm_pkg::PIX_W;
  localparam int RW = sgm_pkg::ROW_W;
  localparam int SW = sgm_pkg::SUM_W;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_CALC = 1'b1;

  logic state_r, state_nxt;

  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rdata_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [PW-1:0] px_r;
  logic [CW-1:0] addr_r;
  logic          emit_r;
  logic [RW-1:0] orow_r;
  logic [sgm_pkg::COL_W-1:0] ocol_r;
  logic          last_r;

  logic [PW-1:0] a_t_r, a_m_r, a_b_r, b_t_r, b_m_r, b_b_r;

  logic [WW-1:0] w;
  logic [RW-1:0] h;
  logic [12:0]   w13, lw13;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [12:0]   r_inc;
  logic [WW-1:0] c1;
  logic [12:0]   c0m1;
  logic          emit;
  logic          last;
  logic          accept;
  logic          leave;
  logic [PW-1:0] ct, cm, cb;
  logic signed [SW-1:0] sx, sy;

  assign lw13 = 13'(cfg.line_width);
  assign w13  = (lw13 < 13'd3) ? 13'd3 :
                ((lw13 > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : lw13);
  assign w    = w13[WW-1:0];
  assign h    = (cfg.frame_height < sgm_pkg::MIN_DIM) ? sgm_pkg::MIN_DIM
                                                      : cfg.frame_height;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // position of this beat and of the next one
  always_comb begin
    c0    = in_data.frame_start ? '0 : col_r;
    r0    = in_data.frame_start ? '0 : row_r;
    r_inc = '0;
    if (WW'(c0) >= w) begin
      c0    = '0;
      r_inc = 13'(r0) + 13'd1;
      r0    = r_inc[RW-1:0];
    end
    if (r0 >= h) begin
      r0 = '0;
    end
    c1 = WW'(c0) + WW'(1);
    if (c1 >= w) begin
      col_nxt = '0;
      r_inc   = 13'(r0) + 13'd1;
      row_nxt = (r_inc >= 13'(h)) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c1[CW-1:0];
      row_nxt = r0;
    end
    c0m1 = 13'(c0) - 13'd1;
    emit = (r0 >= RW'(2)) && (c0 >= CW'(2));
    last = (r0 == h - RW'(1)) && (WW'(c0) == w - WW'(1));
  end

  assign ct = rdata_r[2*PW-1:PW];
  assign cm = rdata_r[PW-1:0];
  assign cb = px_r;

  always_comb begin
    sx = (SW'(ct) + (SW'(cm) << 1) + SW'(cb)) - (SW'(a_t_r) + (SW'(a_m_r) << 1) + SW'(a_b_r));
    sy = (SW'(a_b_r) + (SW'(b_b_r) << 1) + SW'(cb)) - (SW'(a_t_r) + (SW'(b_t_r) << 1) + SW'(ct));
  end

  assign push_valid              = (state_r == F_CALC) && emit_r;
  assign push_data.sx            = sx;
  assign push_data.sy            = sy;
  assign push_data.out_row       = orow_r;
  assign push_data.out_col       = ocol_r;
  assign push_data.last_of_frame = last_r;

  assign leave = (state_r == F_CALC) && (!emit_r || push_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_CALC;
      end
      F_CALC: begin
        if (leave) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      emit_r  <= 1'b0;
      a_t_r   <= '0;
      a_m_r   <= '0;
      a_b_r   <= '0;
      b_t_r   <= '0;
      b_m_r   <= '0;
      b_b_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        emit_r <= emit;
      end
      if (leave) begin
        a_t_r <= b_t_r;
        a_m_r <= b_m_r;
        a_b_r <= b_b_r;
        b_t_r <= ct;
        b_m_r <= cm;
        b_b_r <= cb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r    <= in_data.pixel;
      addr_r  <= c0;
      orow_r  <= r0 - RW'(1);
      ocol_r  <= c0m1[sgm_pkg::COL_W-1:0];
      last_r  <= last;
      rdata_r <= line_mem[c0];
    end
    if (leave) begin
      line_mem[addr_r] <= {cm, px_r};
    end
  end

endmodule

// File: hw/rtl/sgm_queue.sv
module sgm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sgm_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sgm_pkg::work_t pop_data
);

  localparam int D  = sgm_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);
  localparam int NW = $clog2(D + 1);

  sgm_pkg::work_t slot_r [D];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != NW'(D));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(D - 1)) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == PW'(D - 1)) ? '0 : rp_r + PW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + NW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_data;
  end

endmodule

// File: hw/rtl/sgm_back.sv
module sgm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  sgm_pkg::work_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sgm_pkg::out_t  out_data
);

  localparam int SW = sgm_pkg::SUM_W;
  localparam int VW = sgm_pkg::SQ_W;
  localparam int QW = VW + 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQ   = 2'd1;
  localparam logic [1:0] B_ROOT = 2'd2;
  localparam logic [1:0] B_HOLD = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic signed [SW-1:0] sx_r, sy_r;
  logic [sgm_pkg::ROW_W-1:0] row_r;
  logic [sgm_pkg::COL_W-1:0] col_r;
  logic                      last_r;
  logic [VW-1:0] v_r;
  logic [QW-1:0] root_r;
  logic [VW-1:0] bit_r;
  sgm_pkg::out_t out_r;
  logic          out_valid_r;

  logic signed [2*SW-1:0] sqx, sqy;
  logic [QW-1:0] trial;
  logic          take;
  logic          load_out;

  assign sqx   = (2*SW)'(sx_r) * (2*SW)'(sx_r);
  assign sqy   = (2*SW)'(sy_r) * (2*SW)'(sy_r);
  assign trial = root_r + QW'(bit_r);

  assign pop_ready = (state_r == B_IDLE);
  assign take      = pop_valid && pop_ready;
  assign load_out  = (state_r == B_HOLD) && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (take) state_nxt = B_SQ;
      B_SQ:   state_nxt = B_ROOT;
      B_ROOT: if (bit_r == VW'(1)) state_nxt = B_HOLD;
      B_HOLD: if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // operand capture, bit-pair floor root (one pair per cycle), output load
  always_ff @(posedge clk) begin
    if (take) begin
      sx_r   <= pop_data.sx;
      sy_r   <= pop_data.sy;
      row_r  <= pop_data.out_row;
      col_r  <= pop_data.out_col;
      last_r <= pop_data.last_of_frame;
    end
    if (state_r == B_SQ) begin
      v_r    <= sqx[VW-1:0] + sqy[VW-1:0];
      root_r <= '0;
      bit_r  <= VW'(1) << (VW - 1);
    end
    if (state_r == B_ROOT) begin
      if (QW'(v_r) >= trial) begin
        v_r    <= v_r - trial[VW-1:0];
        root_r <= (root_r >> 1) + QW'(bit_r);
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (load_out) begin
      out_r.magnitude     <= root_r[sgm_pkg::MAG_W-1:0];
      out_r.out_row       <= row_r;
      out_r.out_col       <= col_r;
      out_r.last_of_frame <= last_r;
    end
  end

endmodule

// File: hw/rtl/sobel_gradient_magnitude.sv
// channel | ports                          | beat
// --------+--------------------------------+---------------------------------
// input   | in_valid, in_ready, in_data    | one pixel, frame_start flag
// output  | out_valid, out_ready, out_data | magnitude, row, col, last flag
// config  | cfg_we, cfg_index, cfg_wdata   | line_width / frame_height write
//
// Front takes a pixel while idle (line store read), then updates the window
// and waits for the queue to take any interior result. The back end then runs
// load, square-sum, 11 root iterations and output load, one item at a time.
// A 4-entry queue between front and back; output register parts out_ready.
// Reset (rst_n low, synchronous) clears counters, window and queue; line
// store contents are left as they are.
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sgm_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sgm_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]  cfg_wdata
);

  sgm_pkg::cfg_t  cfg_r;
  sgm_pkg::work_t push_data, pop_data;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width   <= sgm_pkg::LINE_WIDTH_RST;
      cfg_r.frame_height <= sgm_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgm_pkg::CFG_LINE_WIDTH:   cfg_r.line_width   <= cfg_wdata[sgm_pkg::LW_W-1:0];
        sgm_pkg::CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[sgm_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  sgm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sgm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sgm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import sgm_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int MAX_H         = 4095;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 32;

  typedef struct {
    in_t beat;
    bit  hold_until_drained;
  } feed_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = CFG_LINE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  feed_t pixel_feed[$];
  out_t  pending_edges[$];
  bit    in_taken;
  int    send_idle_pct, stall_pct;
  int    hold_asked, hold_served, hold_left;
  int    fail_count, beats_in, edges_out, quiet_cycles, phase_count;

  // predictor state
  logic [LW_W-1:0]  model_width  = LINE_WIDTH_RST;
  logic [FH_W-1:0]  model_height = FRAME_HEIGHT_RST;
  bit   [PIX_W-1:0] upper_row  [MAX_W];
  bit   [PIX_W-1:0] middle_row [MAX_W];
  bit   [47:0]      win_cols;
  int               col_pos, row_pos;

  sobel_gradient_magnitude u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int clamp_dim(input int v, input int hi);
    return (v < 3) ? 3 : (v > hi) ? hi : v;
  endfunction

  function automatic int floor_root(input int v);
    int root;
    int trial;
    root = 0;
    for (int b = 10; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic compute_sobel(input in_t beat);
    int   w, h, r, c;
    int   ct, cm, cb, at, am, ab, bt, bb, sx, sy;
    out_t want;
    w = clamp_dim(model_width, MAX_W);
    h = clamp_dim(model_height, MAX_H);
    if (beat.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    ct = upper_row[c];
    cm = middle_row[c];
    cb = beat.pixel;
    upper_row[c]  = PIX_W'(cm);
    middle_row[c] = beat.pixel;
    at = win_cols[47:40];
    am = win_cols[39:32];
    ab = win_cols[31:24];
    bt = win_cols[23:16];
    bb = win_cols[7:0];
    if (r >= 2 && c >= 2) begin
      sx = (ct + 2 * cm + cb) - (at + 2 * am + ab);
      sy = (ab + 2 * bb + cb) - (at + 2 * bt + ct);
      want.magnitude     = MAG_W'(floor_root(sx * sx + sy * sy));
      want.out_row       = ROW_W'(r - 1);
      want.out_col       = COL_W'(c - 1);
      want.last_of_frame = (r == h - 1) && (c == w - 1);
      pending_edges.push_back(want);
    end
    win_cols = {win_cols[23:0], PIX_W'(ct), PIX_W'(cm), beat.pixel};
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic log_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    if (idx == CFG_LINE_WIDTH) model_width = LW_W'(value);
    else model_height = FH_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(input int px, input bit fs);
    feed_t f;
    f.beat.pixel       = PIX_W'(px);
    f.beat.frame_start = fs;
    f.hold_until_drained = 1'b0;
    pixel_feed.push_back(f);
  endtask

  // frames of w x h; noisy adds stray frame starts
  task automatic queue_frames(input int w, input int h, input int count,
                              input bit noisy, input bit open_fresh);
    int pos, style, px;
    bit fs;
    pos   = 0;
    style = 0;
    for (int i = 0; i < count; i++) begin
      fs = (i == 0) ? open_fresh : (pos == 0 && $urandom_range(1) == 1);
      if (noisy && $urandom_range(99) < 3) begin
        fs  = 1'b1;
        pos = 0;
      end
      if (pos == 0) style = $urandom_range(2);
      case (style)
        0: px = $urandom_range(255);
        1: px = ($urandom_range(1) == 1) ? 255 : 0;
        default: px = (pos * 5 + $urandom_range(15)) & 255;
      endcase
      queue_pixel(px, fs);
      pos = (pos + 1) % (w * h);
    end
  endtask

  task automatic wait_idle();
    while (pixel_feed.size() != 0 || in_valid || pending_edges.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    feed_t nf;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pixel_feed[0].hold_until_drained && pending_edges.size() != 0)) begin
        nf = pixel_feed.pop_front();
        in_valid <= 1'b1;
        in_data  <= nf.beat;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        beats_in++;
        compute_sobel(in_data);
      end
      if (out_valid && out_ready) begin
        edges_out++;
        if (pending_edges.size() == 0) begin
          log_mismatch($sformatf("unexpected beat row %0d col %0d mag %0d",
                                 out_data.out_row, out_data.out_col, out_data.magnitude));
        end else begin
          want = pending_edges.pop_front();
          if (out_data.magnitude !== want.magnitude)
            log_mismatch($sformatf("magnitude %0d, want %0d at row %0d col %0d",
                                   out_data.magnitude, want.magnitude,
                                   want.out_row, want.out_col));
          if (out_data.out_row !== want.out_row)
            log_mismatch($sformatf("out_row %0d, want %0d", out_data.out_row, want.out_row));
          if (out_data.out_col !== want.out_col)
            log_mismatch($sformatf("out_col %0d, want %0d", out_data.out_col, want.out_col));
          if (out_data.last_of_frame !== want.last_of_frame)
            log_mismatch($sformatf("last_of_frame %0b, want %0b at row %0d col %0d",
                                   out_data.last_of_frame, want.last_of_frame,
                                   want.out_row, want.out_col));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_edges.size());
        $display("FAIL sobel_gradient_magnitude");
        $finish;
      end
    end
  end

  initial begin
    bit [PIX_W-1:0] shape [15];
    int lw, fh, w, h;
    shape = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: 3x5 frame, wrap without frame start, restart mid-row
    write_reg(CFG_LINE_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 5);
    foreach (shape[i]) queue_pixel(shape[i], i == 0);
    queue_pixel(255, 1'b0);
    queue_pixel(0, 1'b0);
    for (int i = 0; i < 9; i++) queue_pixel((i % 3 == 2) ? 255 : i * 20, i == 0);
    wait_idle();

    // widest rows, shortest frame; writes every line store entry
    write_reg(CFG_LINE_WIDTH, 1023);
    write_reg(CFG_FRAME_HEIGHT, 1);
    queue_frames(MAX_W, 3, MAX_W * 2 + 24, 1'b0, 1'b1);
    wait_idle();

    // tallest frame setting, partial; long output hold fills the block
    send_idle_pct = 16;
    stall_pct     = 16;
    write_reg(CFG_LINE_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, MAX_H);
    hold_asked++;
    queue_frames(3, MAX_H, 120, 1'b0, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 16; ph++) begin
      wait_idle();
      case (ph / 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      lw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
      lw = lw | ($urandom_range(3) << LW_W);
      fh = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
      write_reg(CFG_LINE_WIDTH, lw);
      write_reg(CFG_FRAME_HEIGHT, fh);
      w = clamp_dim(LW_W'(lw), MAX_W);
      h = clamp_dim(fh, MAX_H);
      // about a quarter of phases carry on mid-frame under the new setting
      queue_frames(w, h, PHASE_ITEMS, 1'b1, $urandom_range(3) != 0);
      pixel_feed[pixel_feed.size() / 2].hold_until_drained = 1'b1;
      phase_count++;
    end
    wait_idle();

    $display("run: %0d pixel beats in, %0d results checked over %0d random phases",
             beats_in, edges_out, phase_count);
    $display("run: widths 3..512 and heights 3..4095 with clamped writes, mid-frame ",
             "setting changes, long output hold and drain pauses");
    if (fail_count == 0) begin
      $display("PASS sobel_gradient_magnitude");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL sobel_gradient_magnitude");
    end
    $finish;
  end

endmodule
